// File: rtl/vmy_pkg.sv
package vmy_pkg;

  localparam int IN_W      = 32;
  localparam int DIFF_W    = IN_W + 1;
  localparam int NUM_W     = IN_W + 3;
  localparam int SQ_W      = 2 * IN_W + 1;
  localparam int SHSQ_W    = 2 * IN_W;
  localparam int SUMA_W    = SQ_W + 2;
  localparam int SIXJ2_W   = SUMA_W + 1;
  localparam int Q_W       = 34;
  localparam int TRIAL_W   = 72;
  localparam int DEN_W     = Q_W + 3;
  localparam int MAG_W     = NUM_W - 1;
  localparam int GRAD_FRAC = 16;
  localparam int QUOT_BITS = 18;
  localparam int GRAD_W    = 18;
  localparam int DVD_W     = MAG_W + GRAD_FRAC;
  localparam int CMP_W     = DEN_W + QUOT_BITS;
  localparam int LANE_LAT  = QUOT_BITS + 3;
  localparam int LIM_W     = 31;
  localparam int NUM_LANES = 6;

  localparam logic [QUOT_BITS-1:0] GRAD_POS_MAX = QUOT_BITS'(131071);
  localparam logic [QUOT_BITS-1:0] GRAD_NEG_MAG = QUOT_BITS'(131072);

  typedef struct packed {
    logic signed [NUM_W-1:0] num_xx;
    logic signed [NUM_W-1:0] num_yy;
    logic signed [NUM_W-1:0] num_zz;
    logic signed [IN_W-1:0]  sh_yz;
    logic signed [IN_W-1:0]  sh_xz;
    logic signed [IN_W-1:0]  sh_xy;
  } side_t;

endpackage

// File: rtl/vmy_j2.sv
module vmy_j2 import vmy_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [IN_W-1:0] sxx_i,
  input  logic signed [IN_W-1:0] syy_i,
  input  logic signed [IN_W-1:0] szz_i,
  input  logic signed [IN_W-1:0] syz_i,
  input  logic signed [IN_W-1:0] sxz_i,
  input  logic signed [IN_W-1:0] sxy_i,
  output logic                   valid_o,
  output logic [SIXJ2_W-1:0]     six_j2_o,
  output side_t                  side_o
);

  logic va_q, vb_q, vc_q, vd_q, ve_q;
  logic signed [IN_W-1:0] sxx_q, syy_q, szz_q, syz_q, sxz_q, sxy_q;

  logic signed [DIFF_W-1:0] dxy, dyz, dzx;
  logic signed [NUM_W-1:0]  exx, eyy, ezz;
  logic [DIFF_W-1:0] d1_q, d2_q, d3_q;
  logic [IN_W-1:0]   m4_q, m5_q, m6_q;
  side_t side_b_q, side_c_q, side_d_q, side_e_q;

  logic [2*DIFF_W-1:0] p1, p2, p3;
  logic [SQ_W-1:0]     sq1_q, sq2_q, sq3_q;
  logic [SHSQ_W-1:0]   sq4_q, sq5_q, sq6_q;
  logic [SUMA_W-1:0]   suma_q;
  logic [SHSQ_W-1:0]   sumb_q;
  logic [SIXJ2_W-1:0]  six_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      sxx_q <= sxx_i;
      syy_q <= syy_i;
      szz_q <= szz_i;
      syz_q <= syz_i;
      sxz_q <= sxz_i;
      sxy_q <= sxy_i;
    end
  end

  assign dxy = DIFF_W'(sxx_q) - DIFF_W'(syy_q);
  assign dyz = DIFF_W'(syy_q) - DIFF_W'(szz_q);
  assign dzx = DIFF_W'(szz_q) - DIFF_W'(sxx_q);
  assign exx = (NUM_W'(sxx_q) <<< 1) - NUM_W'(syy_q) - NUM_W'(szz_q);
  assign eyy = (NUM_W'(syy_q) <<< 1) - NUM_W'(sxx_q) - NUM_W'(szz_q);
  assign ezz = (NUM_W'(szz_q) <<< 1) - NUM_W'(sxx_q) - NUM_W'(syy_q);

  // Stage B: magnitudes of differences and shears, deviatoric numerators.
  always_ff @(posedge clk_i) begin
    d1_q <= dxy[DIFF_W-1] ? DIFF_W'(-dxy) : DIFF_W'(dxy);
    d2_q <= dyz[DIFF_W-1] ? DIFF_W'(-dyz) : DIFF_W'(dyz);
    d3_q <= dzx[DIFF_W-1] ? DIFF_W'(-dzx) : DIFF_W'(dzx);
    m4_q <= syz_q[IN_W-1] ? IN_W'(-syz_q) : IN_W'(syz_q);
    m5_q <= sxz_q[IN_W-1] ? IN_W'(-sxz_q) : IN_W'(sxz_q);
    m6_q <= sxy_q[IN_W-1] ? IN_W'(-sxy_q) : IN_W'(sxy_q);
    side_b_q.num_xx <= exx;
    side_b_q.num_yy <= eyy;
    side_b_q.num_zz <= ezz;
    side_b_q.sh_yz  <= syz_q;
    side_b_q.sh_xz  <= sxz_q;
    side_b_q.sh_xy  <= sxy_q;
  end

  assign p1 = d1_q * d1_q;
  assign p2 = d2_q * d2_q;
  assign p3 = d3_q * d3_q;

  // Stage C: squares. Stage D: partial sums. Stage E: six times J2.
  always_ff @(posedge clk_i) begin
    sq1_q    <= p1[SQ_W-1:0];
    sq2_q    <= p2[SQ_W-1:0];
    sq3_q    <= p3[SQ_W-1:0];
    sq4_q    <= m4_q * m4_q;
    sq5_q    <= m5_q * m5_q;
    sq6_q    <= m6_q * m6_q;
    side_c_q <= side_b_q;
    suma_q   <= SUMA_W'(sq1_q) + SUMA_W'(sq2_q) + SUMA_W'(sq3_q);
    sumb_q   <= sq4_q + sq5_q + sq6_q;
    side_d_q <= side_c_q;
    six_q    <= SIXJ2_W'(suma_q) + (SIXJ2_W'(sumb_q) << 2) + (SIXJ2_W'(sumb_q) << 1);
    side_e_q <= side_d_q;
  end

  assign valid_o  = ve_q;
  assign six_j2_o = six_q;
  assign side_o   = side_e_q;

endmodule

// File: rtl/vmy_sqrt.sv
module vmy_sqrt import vmy_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [SIXJ2_W-1:0] six_j2_i,
  input  side_t              side_i,
  output logic               valid_o,
  output logic [Q_W-1:0]     root_o,
  output side_t              side_o
);

  // One result bit per stage; the remainder is six_j2 minus six times root squared.
  logic               v_q    [Q_W];
  logic [SIXJ2_W-1:0] rem_q  [Q_W];
  logic [Q_W-1:0]     res_q  [Q_W];
  side_t              side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic               v_in;
    logic [SIXJ2_W-1:0] rem_in;
    logic [Q_W-1:0]     res_in;
    side_t              side_in;
    logic [TRIAL_W-1:0] base, trial;
    logic               take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = six_j2_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign base  = (TRIAL_W'(res_in) << (B + 1)) | (TRIAL_W'(1) << (2 * B));
    assign trial = (base << 2) + (base << 1);
    assign take  = TRIAL_W'(rem_in) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? SIXJ2_W'(TRIAL_W'(rem_in) - trial) : rem_in;
      res_q[k]  <= take ? (res_in | (Q_W'(1) << B)) : res_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign root_o  = res_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

// File: rtl/vmy_div_lane.sv
module vmy_div_lane import vmy_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]         den_i,
  output logic signed [GRAD_W-1:0] grad_o
);

  logic [MAG_W-1:0] mag_q;
  logic [DEN_W-1:0] den0_q;
  logic             neg0_q;

  logic [DVD_W-1:0]     rem_q  [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] quot_q [QUOT_BITS+1];
  logic [DEN_W-1:0]     den_q  [QUOT_BITS+1];
  logic                 neg_q  [QUOT_BITS+1];
  logic                 ovf_q  [QUOT_BITS+1];

  logic [DVD_W-1:0]     dvd;
  logic [QUOT_BITS-1:0] mag_c;
  logic signed [GRAD_W-1:0] grad_q;

  always_ff @(posedge clk_i) begin
    mag_q  <= num_i[NUM_W-1] ? MAG_W'(-num_i) : MAG_W'(num_i);
    den0_q <= den_i;
    neg0_q <= num_i[NUM_W-1];
  end

  assign dvd = {mag_q, {GRAD_FRAC{1'b0}}};

  // A quotient of 2^QUOT_BITS or more saturates; flag it before the steps.
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= dvd;
    quot_q[0] <= '0;
    den_q[0]  <= den0_q;
    neg_q[0]  <= neg0_q;
    ovf_q[0]  <= CMP_W'(dvd) >= (CMP_W'(den0_q) << QUOT_BITS);
  end

  for (genvar s = 0; s < QUOT_BITS; s++) begin : g_step
    localparam int I = QUOT_BITS - 1 - s;
    logic [CMP_W-1:0] sub;
    logic             take;

    assign sub  = CMP_W'(den_q[s]) << I;
    assign take = CMP_W'(rem_q[s]) >= sub;

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= take ? DVD_W'(CMP_W'(rem_q[s]) - sub) : rem_q[s];
      quot_q[s+1] <= take ? (quot_q[s] | (QUOT_BITS'(1) << I)) : quot_q[s];
      den_q[s+1]  <= den_q[s];
      neg_q[s+1]  <= neg_q[s];
      ovf_q[s+1]  <= ovf_q[s];
    end
  end

  always_comb begin
    if (neg_q[QUOT_BITS]) begin
      mag_c = (ovf_q[QUOT_BITS] || quot_q[QUOT_BITS] > GRAD_NEG_MAG) ? GRAD_NEG_MAG
                                                                      : quot_q[QUOT_BITS];
    end else begin
      mag_c = (ovf_q[QUOT_BITS] || quot_q[QUOT_BITS] > GRAD_POS_MAX) ? GRAD_POS_MAX
                                                                      : quot_q[QUOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    grad_q <= neg_q[QUOT_BITS] ? GRAD_W'(-mag_c) : GRAD_W'(mag_c);
  end

  assign grad_o = grad_q;

endmodule

// File: rtl/von_mises_yield_and_gradient.sv
// A result strobes valid_o after passing the J2 front end, square root, divisor, lane and merge stages.
// Throughput: one stress state per cycle; busy stays low, so start may be high every cycle.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
// Reset (rst_ni low, asynchronous) clears the pipeline valid bits and the shear limit.
module von_mises_yield_and_gradient import vmy_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cfg_we_i,
  input  logic [LIM_W-1:0]         cfg_wdata_i,
  input  logic signed [IN_W-1:0]   stress_xx_i,
  input  logic signed [IN_W-1:0]   stress_yy_i,
  input  logic signed [IN_W-1:0]   stress_zz_i,
  input  logic signed [IN_W-1:0]   shear_yz_i,
  input  logic signed [IN_W-1:0]   shear_xz_i,
  input  logic signed [IN_W-1:0]   shear_xy_i,
  output logic                     valid_o,
  output logic signed [IN_W-1:0]   yield_value_o,
  output logic signed [GRAD_W-1:0] grad_xx_o,
  output logic signed [GRAD_W-1:0] grad_yy_o,
  output logic signed [GRAD_W-1:0] grad_zz_o,
  output logic signed [GRAD_W-1:0] grad_yz_o,
  output logic signed [GRAD_W-1:0] grad_xz_o,
  output logic signed [GRAD_W-1:0] grad_xy_o,
  output logic                     zero_invariant_o
);

  // The pipeline never stalls: every stage advances each cycle and the timing of a
  // transaction is fixed. The front end forms six times J2 exactly (five stages),
  // a 34-stage digit-by-digit square root compares six times each trial root squared
  // against that sum so no division by six is needed, one stage forms the divisors,
  // six divider lanes work in parallel, and a merge stage assembles
  // the yield value and the gradient.

  logic [LIM_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  logic               j2_valid;
  logic [SIXJ2_W-1:0] six_j2;
  side_t              j2_side;

  vmy_j2 u_j2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start && !busy),
    .sxx_i    (stress_xx_i),
    .syy_i    (stress_yy_i),
    .szz_i    (stress_zz_i),
    .syz_i    (shear_yz_i),
    .sxz_i    (shear_xz_i),
    .sxy_i    (shear_xy_i),
    .valid_o  (j2_valid),
    .six_j2_o (six_j2),
    .side_o   (j2_side)
  );

  logic           rt_valid;
  logic [Q_W-1:0] root;
  side_t          rt_side;

  vmy_sqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (j2_valid),
    .six_j2_i (six_j2),
    .side_i   (j2_side),
    .valid_o  (rt_valid),
    .root_o   (root),
    .side_o   (rt_side)
  );

  // Divisor stage: normal components divide by six times the root, shears by the root.
  logic             dv_valid_q;
  logic [Q_W-1:0]   dv_root_q;
  logic             dv_zero_q;
  logic [DEN_W-1:0] den_n_q, den_s_q;
  side_t            dv_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q <= 1'b0;
    end else begin
      dv_valid_q <= rt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_root_q <= root;
    dv_zero_q <= (root == '0);
    den_n_q   <= (DEN_W'(root) << 2) + (DEN_W'(root) << 1);
    den_s_q   <= DEN_W'(root);
    dv_side_q <= rt_side;
  end

  logic signed [NUM_W-1:0]  lane_num  [NUM_LANES];
  logic [DEN_W-1:0]         lane_den  [NUM_LANES];
  logic signed [GRAD_W-1:0] lane_grad [NUM_LANES];

  assign lane_num[0] = dv_side_q.num_xx;
  assign lane_num[1] = dv_side_q.num_yy;
  assign lane_num[2] = dv_side_q.num_zz;
  assign lane_num[3] = NUM_W'(dv_side_q.sh_yz);
  assign lane_num[4] = NUM_W'(dv_side_q.sh_xz);
  assign lane_num[5] = NUM_W'(dv_side_q.sh_xy);
  assign lane_den[0] = den_n_q;
  assign lane_den[1] = den_n_q;
  assign lane_den[2] = den_n_q;
  assign lane_den[3] = den_s_q;
  assign lane_den[4] = den_s_q;
  assign lane_den[5] = den_s_q;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    vmy_div_lane u_lane (
      .clk_i  (clk_i),
      .num_i  (lane_num[l]),
      .den_i  (lane_den[l]),
      .grad_o (lane_grad[l])
    );
  end

  // The root, the zero flag and the valid bit wait alongside the lanes.
  logic           dly_valid_q [LANE_LAT];
  logic [Q_W-1:0] dly_root_q  [LANE_LAT];
  logic           dly_zero_q  [LANE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        dly_valid_q[i] <= 1'b0;
      end
    end else begin
      dly_valid_q[0] <= dv_valid_q;
      for (int i = 1; i < LANE_LAT; i++) begin
        dly_valid_q[i] <= dly_valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dly_root_q[0] <= dv_root_q;
    dly_zero_q[0] <= dv_zero_q;
    for (int i = 1; i < LANE_LAT; i++) begin
      dly_root_q[i] <= dly_root_q[i-1];
      dly_zero_q[i] <= dly_zero_q[i-1];
    end
  end

  // Merge stage. The root is never negative and the limit stays below 2^31, so the
  // difference can only overflow upward.
  logic signed [Q_W:0]     yield_diff;
  logic signed [IN_W-1:0]  yield_d;
  logic                    zero_now;

  assign zero_now   = dly_zero_q[LANE_LAT-1];
  assign yield_diff = $signed({1'b0, dly_root_q[LANE_LAT-1]}) - $signed((Q_W + 1)'(limit_q));
  assign yield_d    = (yield_diff > $signed((Q_W + 1)'(32'h7FFF_FFFF)))
                      ? IN_W'(32'h7FFF_FFFF) : IN_W'(yield_diff);

  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dly_valid_q[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    yield_value_o    <= yield_d;
    grad_xx_o        <= zero_now ? '0 : lane_grad[0];
    grad_yy_o        <= zero_now ? '0 : lane_grad[1];
    grad_zz_o        <= zero_now ? '0 : lane_grad[2];
    grad_yz_o        <= zero_now ? '0 : lane_grad[3];
    grad_xz_o        <= zero_now ? '0 : lane_grad[4];
    grad_xy_o        <= zero_now ? '0 : lane_grad[5];
    zero_invariant_o <= zero_now;
  end

  assign valid_o = valid_q;

endmodule
